/* rtl/cc20_pkg.sv */
package cc20_pkg;

  // Block function size
  localparam int DOUBLE_ROUNDS = 10;
  // Two half quarter-rounds per round, two rounds per double round
  localparam int ROUND_STEPS   = DOUBLE_ROUNDS * 4;
  localparam int STEP_W        = $clog2(ROUND_STEPS);

  // Keystream block is eight 64-bit chunks
  localparam int CHUNKS  = 8;
  localparam int CHUNK_W = $clog2(CHUNKS);

  typedef logic [31:0]        word_t;
  typedef logic [15:0][31:0]  block_t;
  typedef logic [63:0]        chunk_t;
  typedef logic [CHUNK_W-1:0] chunk_idx_t;

  // Configuration register indexes
  typedef logic [2:0] cfg_idx_t;
  localparam cfg_idx_t CFG_KEY_PART_0      = 3'd0;
  localparam cfg_idx_t CFG_KEY_PART_1      = 3'd1;
  localparam cfg_idx_t CFG_KEY_PART_2      = 3'd2;
  localparam cfg_idx_t CFG_KEY_PART_3      = 3'd3;
  localparam cfg_idx_t CFG_NONCE_LOW       = 3'd4;
  localparam cfg_idx_t CFG_NONCE_HIGH      = 3'd5;
  localparam cfg_idx_t CFG_INITIAL_COUNTER = 3'd6;

  // "expand 32-byte k"
  localparam word_t SIGMA_0 = 32'h6170_7865;
  localparam word_t SIGMA_1 = 32'h3320_646e;
  localparam word_t SIGMA_2 = 32'h7962_2d32;
  localparam word_t SIGMA_3 = 32'h6b20_6574;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load_item;  // input beat taken this cycle
    logic round;      // apply one half quarter-round step to all four columns/diagonals
    logic diag;       // diagonal round when set, column round otherwise
    logic second;     // second half of the quarter-round (rotations 8 and 7)
    logic finish;     // add the initial state, write the keystream block
    logic emit;       // load the output register
  } cc20_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic need_block; // pending input beat needs a fresh keystream block
  } cc20_sts_t;

  typedef struct packed {
    word_t a;
    word_t b;
    word_t c;
    word_t d;
  } qr_t;

  function automatic word_t rotl(word_t v, int n);
    return (v << n) | (v >> (32 - n));
  endfunction

  // Half of a quarter-round: two adds, two xor-rotates
  function automatic qr_t qr_half(word_t a, word_t b, word_t c, word_t d, logic second);
    qr_t   r;
    word_t ta;
    word_t tb;
    word_t tc;
    word_t td;
    ta = a + b;
    td = d ^ ta;
    td = second ? rotl(td, 8) : rotl(td, 16);
    tc = c + td;
    tb = b ^ tc;
    tb = second ? rotl(tb, 7) : rotl(tb, 12);
    r.a = ta;
    r.b = tb;
    r.c = tc;
    r.d = td;
    return r;
  endfunction

  // Initial state: constants, key, counter, nonce
  function automatic block_t init_words(logic [255:0] key, logic [95:0] nonce, word_t ctr);
    block_t w;
    w[0] = SIGMA_0;
    w[1] = SIGMA_1;
    w[2] = SIGMA_2;
    w[3] = SIGMA_3;
    for (int i = 0; i < 8; i++) begin
      w[4 + i] = key[32*i +: 32];
    end
    w[12] = ctr;
    w[13] = nonce[31:0];
    w[14] = nonce[63:32];
    w[15] = nonce[95:64];
    return w;
  endfunction

  // Byte enables for a clamped byte count of 0..8
  function automatic chunk_t byte_mask(logic [3:0] cnt);
    chunk_t m;
    for (int j = 0; j < 8; j++) begin
      m[8*j +: 8] = (4'(j) < cnt) ? 8'hff : 8'h00;
    end
    return m;
  endfunction

endpackage

/* rtl/cc20_ctrl.sv */
module cc20_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  output logic                out_valid,
  input  logic                out_stall,
  input  cc20_pkg::cc20_sts_t sts,
  output cc20_pkg::cc20_cmd_t cmd
);
  import cc20_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_ROUND = 4'b0010,
    ST_FINAL = 4'b0100,
    ST_EMIT  = 4'b1000
  } state_t;

  state_t            state_r, state_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              in_take;
  logic              out_free;

  assign in_take   = in_valid && (state_r == ST_IDLE);
  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

  // Command decode
  always_comb begin
    cmd.load_item = in_take;
    cmd.round     = (state_r == ST_ROUND);
    cmd.diag      = step_r[1];
    cmd.second    = step_r[0];
    cmd.finish    = (state_r == ST_FINAL);
    cmd.emit      = (state_r == ST_EMIT) && out_free;
  end

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    unique case (state_r)
      ST_IDLE: begin
        step_nxt = '0;
        if (in_valid) begin
          state_nxt = sts.need_block ? ST_ROUND : ST_EMIT;
        end
      end
      ST_ROUND: begin
        step_nxt = step_r + 1'b1;
        if (step_r == STEP_W'(ROUND_STEPS - 1)) begin
          state_nxt = ST_FINAL;
        end
      end
      ST_FINAL: begin
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Output beat valid: set on emit, cleared when taken
  assign out_valid_nxt = cmd.emit ? 1'b1 : (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

/* rtl/cc20_datapath.sv */
module cc20_datapath (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  cc20_pkg::cfg_idx_t  cfg_index,
  input  logic [63:0]         cfg_wdata,
  input  logic [63:0]         in_data_in,
  input  logic [3:0]          in_byte_count,
  input  logic                in_first_chunk,
  input  cc20_pkg::cc20_cmd_t cmd,
  output cc20_pkg::cc20_sts_t sts,
  output logic [63:0]         out_data_out,
  output logic [3:0]          out_out_count
);
  import cc20_pkg::*;

  // Configuration
  logic [255:0] key_r;
  logic [95:0]  nonce_r;
  word_t        init_ctr_r;

  // Stream position
  word_t        ctr_r;
  chunk_idx_t   pos_r;

  // Working state and keystream
  block_t       w_r, w_nxt;
  chunk_t       ks_r [CHUNKS];

  // Held input beat and output register
  chunk_t       data_r;
  logic [3:0]   count_r;
  chunk_t       odata_r;
  logic [3:0]   ocount_r;

  word_t        ctr_sel;
  block_t       start_w;
  block_t       final_init;
  block_t       step_w;
  logic [3:0]   count_clamp;

  assign sts.need_block = in_first_chunk || (pos_r == '0);
  assign ctr_sel        = in_first_chunk ? init_ctr_r : ctr_r;
  assign start_w        = init_words(key_r, nonce_r, ctr_sel);
  assign final_init     = init_words(key_r, nonce_r, ctr_r);
  assign count_clamp    = (count_r > 4'd8) ? 4'd8 : count_r;

  // Four quarter-round units, half a quarter-round per cycle
  always_comb begin
    qr_t        r;
    logic [3:0] ia;
    logic [3:0] ib;
    logic [3:0] ic;
    logic [3:0] id;
    step_w = w_r;
    for (int i = 0; i < 4; i++) begin
      ia = 4'(i);
      ib = cmd.diag ? 4'(4 + ((i + 1) & 3))  : 4'(4 + i);
      ic = cmd.diag ? 4'(8 + ((i + 2) & 3))  : 4'(8 + i);
      id = cmd.diag ? 4'(12 + ((i + 3) & 3)) : 4'(12 + i);
      r  = qr_half(w_r[ia], w_r[ib], w_r[ic], w_r[id], cmd.second);
      step_w[ia] = r.a;
      step_w[ib] = r.b;
      step_w[ic] = r.c;
      step_w[id] = r.d;
    end
  end

  always_comb begin
    w_nxt = w_r;
    priority if (cmd.load_item) begin
      w_nxt = start_w;
    end else if (cmd.round) begin
      w_nxt = step_w;
    end else begin
      w_nxt = w_r;
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r      <= '0;
      nonce_r    <= '0;
      init_ctr_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_KEY_PART_0:      key_r[63:0]    <= cfg_wdata;
        CFG_KEY_PART_1:      key_r[127:64]  <= cfg_wdata;
        CFG_KEY_PART_2:      key_r[191:128] <= cfg_wdata;
        CFG_KEY_PART_3:      key_r[255:192] <= cfg_wdata;
        CFG_NONCE_LOW:       nonce_r[63:0]  <= cfg_wdata;
        CFG_NONCE_HIGH:      nonce_r[95:64] <= cfg_wdata[31:0];
        CFG_INITIAL_COUNTER: init_ctr_r     <= cfg_wdata[31:0];
        default: ;
      endcase
    end
  end

  // Block counter and chunk position
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctr_r <= '0;
      pos_r <= '0;
    end else begin
      if (cmd.load_item && in_first_chunk) begin
        ctr_r <= init_ctr_r;
        pos_r <= '0;
      end
      if (cmd.finish) begin
        ctr_r <= ctr_r + 1'b1;
      end
      if (cmd.emit) begin
        pos_r <= pos_r + 1'b1;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    w_r <= w_nxt;
    if (cmd.load_item) begin
      data_r  <= in_data_in;
      count_r <= in_byte_count;
    end
    // Feed-forward add and keystream write
    if (cmd.finish) begin
      for (int k = 0; k < CHUNKS; k++) begin
        ks_r[k] <= {w_r[4'(2*k + 1)] + final_init[4'(2*k + 1)],
                    w_r[4'(2*k)]     + final_init[4'(2*k)]};
      end
    end
    if (cmd.emit) begin
      odata_r  <= (data_r ^ ks_r[pos_r]) & byte_mask(count_clamp);
      ocount_r <= count_clamp;
    end
  end

  assign out_data_out  = odata_r;
  assign out_out_count = ocount_r;

endmodule

/* rtl/chacha20_stream_xor.sv */
// ChaCha20 stream cipher (RFC 8439 layout: 256-bit key, 96-bit nonce, 32-bit block
// counter); the same beat flow encrypts and decrypts. Each input beat carries up to
// eight message bytes, byte 0 in bits 7:0, and returns one output beat with those
// bytes XORed with the next eight keystream bytes; bytes past the count read zero and
// counts above eight act as eight. A beat with first_chunk set reloads the counter
// from initial_counter and starts a fresh keystream block. A beat that uses a cached
// keystream chunk goes straight to the output register; a beat that needs a new
// 64-byte block first runs the rounds on four quarter-round units that each complete
// half a quarter-round per cycle. A full block serves eight beats; input stalls until
// the beat is emitted. Write key, nonce and counter registers only while idle.
module chacha20_stream_xor (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  cc20_pkg::cfg_idx_t cfg_index,
  input  logic [63:0]        cfg_wdata,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [63:0]        in_data_in,
  input  logic [3:0]         in_byte_count,
  input  logic               in_first_chunk,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [63:0]        out_data_out,
  output logic [3:0]         out_out_count
);
  import cc20_pkg::*;

  cc20_cmd_t cmd;
  cc20_sts_t sts;

  cc20_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  cc20_datapath u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_data_in     (in_data_in),
    .in_byte_count  (in_byte_count),
    .in_first_chunk (in_first_chunk),
    .cmd            (cmd),
    .sts            (sts),
    .out_data_out   (out_data_out),
    .out_out_count  (out_out_count)
  );

endmodule

/* test/chacha20_stream_xor_check.sv */
module chacha20_stream_xor_check (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  cc20_pkg::cfg_idx_t cfg_index,
  input  logic [63:0]        cfg_wdata,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic [63:0]        in_data_in,
  input  logic [3:0]         in_byte_count,
  input  logic               in_first_chunk,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic [63:0]        out_data_out,
  input  logic [3:0]         out_out_count,
  output int                 mismatches,
  output int                 waiting,
  output int                 checked
);

  import cc20_pkg::*;

  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    chunk_t     data;
    logic [3:0] count;
  } cipher_beat_t;

  // Expected output beats, oldest first
  cipher_beat_t cipher_q[$];

  // Mirror of the key, nonce and counter registers
  logic [255:0] key_bits;
  logic [95:0]  nonce_bits;
  word_t        ctr_start;

  // Keystream position tracking
  word_t        ctr_next;
  chunk_t       ks_chunks [CHUNKS];
  chunk_idx_t   ks_pos;

  int           err_total;
  int           seen_total;

  initial begin
    err_total  = 0;
    seen_total = 0;
  end

  function automatic word_t rol(word_t v, int n);
    logic [63:0] t;
    t = {v, v} << n;
    return t[63:32];
  endfunction

  function automatic block_t quarter_mix(block_t w, int a, int b, int c, int d);
    w[a] = w[a] + w[b];  w[d] = rol(w[d] ^ w[a], 16);
    w[c] = w[c] + w[d];  w[b] = rol(w[b] ^ w[c], 12);
    w[a] = w[a] + w[b];  w[d] = rol(w[d] ^ w[a], 8);
    w[c] = w[c] + w[d];  w[b] = rol(w[b] ^ w[c], 7);
    return w;
  endfunction

  // One 64-byte keystream block for the given key, nonce and counter
  function automatic block_t keystream_block(logic [255:0] key, logic [95:0] nonce,
                                             word_t ctr);
    block_t st;
    block_t w;
    st[0] = SIGMA_0;
    st[1] = SIGMA_1;
    st[2] = SIGMA_2;
    st[3] = SIGMA_3;
    for (int i = 0; i < 8; i++) begin
      st[4 + i] = key[32*i +: 32];
    end
    st[12] = ctr;
    for (int i = 0; i < 3; i++) begin
      st[13 + i] = nonce[32*i +: 32];
    end
    w = st;
    for (int r = 0; r < DOUBLE_ROUNDS; r++) begin
      // columns
      w = quarter_mix(w, 0, 4, 8, 12);
      w = quarter_mix(w, 1, 5, 9, 13);
      w = quarter_mix(w, 2, 6, 10, 14);
      w = quarter_mix(w, 3, 7, 11, 15);
      // diagonals
      w = quarter_mix(w, 0, 5, 10, 15);
      w = quarter_mix(w, 1, 6, 11, 12);
      w = quarter_mix(w, 2, 7, 8, 13);
      w = quarter_mix(w, 3, 4, 9, 14);
    end
    for (int i = 0; i < 16; i++) begin
      w[i] = w[i] + st[i];
    end
    return w;
  endfunction

  always @(posedge clk) begin : track
    cipher_beat_t want;
    block_t       blk;
    chunk_t       ks;
    chunk_t       mask;
    logic [3:0]   n;
    if (!rst_n) begin
      key_bits   = '0;
      nonce_bits = '0;
      ctr_start  = '0;
      ctr_next   = '0;
      ks_pos     = '0;
      cipher_q.delete();
    end else begin
      // register writes
      if (cfg_we) begin
        case (cfg_index)
          CFG_KEY_PART_0:      key_bits[63:0]    = cfg_wdata;
          CFG_KEY_PART_1:      key_bits[127:64]  = cfg_wdata;
          CFG_KEY_PART_2:      key_bits[191:128] = cfg_wdata;
          CFG_KEY_PART_3:      key_bits[255:192] = cfg_wdata;
          CFG_NONCE_LOW:       nonce_bits[63:0]  = cfg_wdata;
          CFG_NONCE_HIGH:      nonce_bits[95:64] = cfg_wdata[31:0];
          CFG_INITIAL_COUNTER: ctr_start         = cfg_wdata[31:0];
          default: ;
        endcase
      end

      // predict the cipher beat for each accepted input beat
      if (in_valid && !in_stall) begin
        if (in_first_chunk) begin
          ctr_next = ctr_start;
          ks_pos   = '0;
        end
        if (ks_pos == '0) begin
          blk = keystream_block(key_bits, nonce_bits, ctr_next);
          for (int i = 0; i < CHUNKS; i++) begin
            ks_chunks[i] = {blk[2*i + 1], blk[2*i]};
          end
          ctr_next = ctr_next + 1'b1;
        end
        ks     = ks_chunks[ks_pos];
        ks_pos = ks_pos + 1'b1;
        // counts above eight act as eight
        n = (in_byte_count > 4'd8) ? 4'd8 : in_byte_count;
        for (int j = 0; j < 8; j++) begin
          mask[8*j +: 8] = (j < n) ? 8'hff : 8'h00;
        end
        want.data  = (in_data_in ^ ks) & mask;
        want.count = n;
        cipher_q.push_back(want);
      end

      // compare each accepted output beat with the oldest expectation
      if (out_valid && !out_stall) begin
        seen_total++;
        if (cipher_q.size() == 0) begin
          err_total++;
          if (err_total <= REPORT_LIMIT) begin
            $display("unexpected output beat: data %h count %0d",
                     out_data_out, out_out_count);
          end
        end else begin
          want = cipher_q.pop_front();
          if (out_data_out !== want.data || out_out_count !== want.count) begin
            err_total++;
            if (err_total <= REPORT_LIMIT) begin
              $display("beat %0d mismatch: expected data %h count %0d, got data %h count %0d",
                       seen_total, want.data, want.count, out_data_out, out_out_count);
            end
          end
        end
      end
    end
    mismatches <= err_total;
    waiting    <= cipher_q.size();
    checked    <= seen_total;
  end

endmodule

/* test/chacha20_stream_xor_test.sv */
module chacha20_stream_xor_test;

  import cc20_pkg::*;

  localparam int PERIOD       = 20;
  localparam int LIMIT_CYCLES = 1_000_000;
  localparam int DRAIN_CYCLES = 100;
  localparam int PHASE_CHUNKS = 300;

  logic         clk = 1'b0;
  logic         rst_n;
  logic         cfg_we;
  cfg_idx_t     cfg_index;
  logic [63:0]  cfg_wdata;
  logic         in_valid;
  logic         in_stall;
  logic [63:0]  in_data_in;
  logic [3:0]   in_byte_count;
  logic         in_first_chunk;
  logic         out_valid;
  logic         out_stall;
  logic [63:0]  out_data_out;
  logic [3:0]   out_out_count;

  logic         no_idle;
  int           cycle_count = 0;
  int           chunks_sent = 0;
  int           messages_sent = 0;
  int           settings_used = 0;
  int           mismatches;
  int           waiting;
  int           checked;

  always #(PERIOD/2) clk = ~clk;

  chacha20_stream_xor dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_data_in     (in_data_in),
    .in_byte_count  (in_byte_count),
    .in_first_chunk (in_first_chunk),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_data_out   (out_data_out),
    .out_out_count  (out_out_count)
  );

  chacha20_stream_xor_check cipher_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_data_in     (in_data_in),
    .in_byte_count  (in_byte_count),
    .in_first_chunk (in_first_chunk),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_data_out   (out_data_out),
    .out_out_count  (out_out_count),
    .mismatches     (mismatches),
    .waiting        (waiting),
    .checked        (checked)
  );

  // Receiver back-pressure
  always @(posedge clk) begin
    out_stall <= !no_idle && ($urandom_range(0, 99) < 8);
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("chacha20_stream_xor_test: errors");
      $finish;
    end
  end

  function automatic chunk_t rand_chunk();
    return {$urandom, $urandom};
  endfunction

  // One register write; the caller lowers the write enable
  task automatic put_reg(input cfg_idx_t idx, input logic [63:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
  endtask

  task automatic set_regs(input logic [63:0] k0, input logic [63:0] k1,
                          input logic [63:0] k2, input logic [63:0] k3,
                          input logic [63:0] n_lo, input logic [63:0] n_hi,
                          input logic [63:0] ctr);
    put_reg(CFG_KEY_PART_0, k0);
    put_reg(CFG_KEY_PART_1, k1);
    put_reg(CFG_KEY_PART_2, k2);
    put_reg(CFG_KEY_PART_3, k3);
    put_reg(CFG_NONCE_LOW, n_lo);
    put_reg(CFG_NONCE_HIGH, n_hi);
    put_reg(CFG_INITIAL_COUNTER, ctr);
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  // One input beat, with an optional random gap before it
  task automatic send_chunk(input chunk_t data, input logic [3:0] cnt, input logic first);
    if (!no_idle) begin
      while ($urandom_range(0, 99) < 8) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid       <= 1'b1;
    in_data_in     <= data;
    in_byte_count  <= cnt;
    in_first_chunk <= first;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    chunks_sent++;
  endtask

  // Drop valid and wait until every cipher beat is back
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (waiting != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Well-formed message: first flag on chunk 0, full chunks with an occasional short one, a tail of one to eight bytes
  task automatic send_message();
    int         len;
    int         pick;
    logic [3:0] cnt;
    pick = $urandom_range(0, 99);
    if (pick < 80) len = $urandom_range(1, 12);
    else if (pick < 95) len = $urandom_range(13, 40);
    else len = $urandom_range(41, 70);
    for (int j = 0; j < len; j++) begin
      cnt = 4'd8;
      if (j == len - 1) cnt = 4'($urandom_range(1, 8));
      else if ($urandom_range(0, 19) == 0) cnt = 4'($urandom_range(1, 7));
      send_chunk(rand_chunk(), cnt, j == 0);
    end
    messages_sent++;
  endtask

  task automatic run_random(input int total);
    int start;
    start = chunks_sent;
    while (chunks_sent - start < total) begin
      // about one in ten is a stray beat with any count and flag
      if ($urandom_range(0, 9) == 0)
        send_chunk(rand_chunk(), 4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)));
      else
        send_message();
    end
  endtask

  initial begin
    rst_n          <= 1'b0;
    cfg_we         <= 1'b0;
    cfg_index      <= CFG_KEY_PART_0;
    cfg_wdata      <= '0;
    in_valid       <= 1'b0;
    in_data_in     <= '0;
    in_byte_count  <= '0;
    in_first_chunk <= 1'b0;
    no_idle        <= 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: all-ones key and nonce, counter at its top value
    set_regs('1, '1, '1, '1, '1, '1, '1);
    // stream with no first chunk since reset uses counter zero
    send_chunk(64'h0, 4'd8, 1'b0);
    send_chunk('1, 4'd8, 1'b0);
    send_chunk(64'haaaa_aaaa_aaaa_aaaa, 4'd3, 1'b0);  // short chunk mid-message
    send_chunk('1, 4'd0, 1'b0);                       // empty chunk
    send_chunk('1, 4'd15, 1'b0);                      // oversized count
    send_chunk(64'h5555_5555_5555_5555, 4'd9, 1'b0);
    repeat (3) send_chunk(rand_chunk(), 4'd8, 1'b0);  // into the second block
    // reload at 0xffffffff and run across the counter wrap
    send_chunk(rand_chunk(), 4'd8, 1'b1);
    for (int c = 1; c <= 8; c++) send_chunk(rand_chunk(), 4'(c), 1'b0);
    send_chunk(rand_chunk(), 4'd8, 1'b0);
    send_chunk(rand_chunk(), 4'd1, 1'b1);
    send_chunk(rand_chunk(), 4'd8, 1'b1);
    send_chunk(rand_chunk(), 4'd12, 1'b1);
    settle();

    // Standard test key and nonce, counter 1
    set_regs(64'h0706_0504_0302_0100, 64'h0f0e_0d0c_0b0a_0908,
             64'h1716_1514_1312_1110, 64'h1f1e_1d1c_1b1a_1918,
             64'h4a00_0000_0900_0000, 64'h0, 64'h1);
    run_random(PHASE_CHUNKS);
    settle();

    // All zero registers, no idling on either side
    no_idle <= 1'b1;
    set_regs('0, '0, '0, '0, '0, '0, '0);
    run_random(PHASE_CHUNKS);
    settle();
    no_idle <= 1'b0;

    // Random key, counter just below the wrap, junk in the unused upper bits
    set_regs(rand_chunk(), rand_chunk(), rand_chunk(), rand_chunk(), rand_chunk(),
             rand_chunk(), {$urandom, 32'hffff_fffe});
    run_random(PHASE_CHUNKS);
    settle();

    // Fully random registers
    set_regs(rand_chunk(), rand_chunk(), rand_chunk(), rand_chunk(), rand_chunk(),
             rand_chunk(), rand_chunk());
    run_random(PHASE_CHUNKS);
    settle();

    // Alternating bit patterns in the key, counter zero
    set_regs(64'haaaa_aaaa_aaaa_aaaa, 64'h5555_5555_5555_5555,
             64'haaaa_aaaa_aaaa_aaaa, 64'h5555_5555_5555_5555, '1, 64'h0, 64'h0);
    run_random(PHASE_CHUNKS);

    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("sent %0d chunks (%0d messages) under %0d register settings",
             chunks_sent, messages_sent, settings_used);
    $display("compared %0d output beats, %0d mismatches", checked, mismatches);
    if (mismatches == 0) begin
      $display("chacha20_stream_xor_test: clean");
    end else begin
      $display("chacha20_stream_xor_test: errors");
    end
    $finish;
  end

endmodule
